// ===== src/pattern_code_coverage_set_defines.svh =====
// assertion macros for the pattern code coverage set
`ifndef PATTERN_CODE_COVERAGE_SET_DEFINES_SVH
`define PATTERN_CODE_COVERAGE_SET_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define PCCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pccs assertion failed");
// next-cycle implication, checked out of reset
`define PCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pccs assertion failed");
`else
`define PCCS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/pccs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pccs_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int VALUE_RANGE = 64;
    localparam int HIST_DEPTH  = MAX_PATTERN - 1;
    localparam int FACT_MAX    = 40320;
    localparam int MAP_WORDS   = (FACT_MAX + 63) / 64;
    localparam int MAP_ADDR_W  = $clog2(MAP_WORDS);

    localparam logic       FUNC_PUSH  = 1'b0;
    localparam logic       FUNC_CLEAR = 1'b1;
    localparam logic [3:0] LEN_RESET  = 4'd3;

    typedef struct packed {
        logic       func;
        logic [5:0] value;
    } t_in_req;

    typedef struct packed {
        logic [15:0] pattern_code;
        logic        newly_found;
        logic [15:0] distinct_count;
        logic        all_found;
    } t_out_res;

    // rank unit -> top
    typedef struct packed {
        logic        complete;
        logic [15:0] code;
    } t_rank_status;

    // top -> rank unit
    typedef struct packed {
        logic push;
        logic restart;
    } t_rank_ctrl;

    function automatic logic [3:0] pccs_eff_len(input logic [3:0] len);
        logic [3:0] k;
        k = len;
        if (k < 4'd2) k = 4'd2;
        if (k > 4'(MAX_PATTERN)) k = 4'(MAX_PATTERN);
        return k;
    endfunction

    function automatic logic [15:0] pccs_fact(input logic [3:0] k);
        logic [15:0] f;
        case (k)
            4'd2:    f = 16'd2;
            4'd3:    f = 16'd6;
            4'd4:    f = 16'd24;
            4'd5:    f = 16'd120;
            4'd6:    f = 16'd720;
            4'd7:    f = 16'd5040;
            4'd8:    f = 16'd40320;
            default: f = 16'd1;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== src/pccs_rank_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pccs_rank_unit import pccs_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_rank_ctrl   i_ctrl,
    input  wire logic [5:0]   i_value,
    input  wire logic [3:0]   i_len,
    output t_rank_status      o_status
);

    logic [5:0]  r_hist [HIST_DEPTH];
    logic [2:0]  r_idx;
    logic [15:0] r_code;

    logic [2:0]  idx_eff;
    logic [15:0] code_eff;
    logic [HIST_DEPTH-1:0] smaller;
    logic [2:0]  rank;
    logic [19:0] prod;
    logic [15:0] code;
    logic        complete;

    always_comb begin
        // an index at or past the length starts a fresh subsequence
        if ({1'b0, r_idx} >= i_len) begin
            idx_eff  = '0;
            code_eff = '0;
        end else begin
            idx_eff  = r_idx;
            code_eff = r_code;
        end
        for (int i = 0; i < HIST_DEPTH; i++) begin
            smaller[i] = (3'(i) < idx_eff) && (r_hist[i] < i_value);
        end
        rank     = 3'($countones(smaller));
        prod     = 20'(code_eff) * 20'({1'b0, idx_eff} + 4'd1);
        code     = prod[15:0] + 16'(rank);
        complete = ({1'b0, idx_eff} + 4'd1) == i_len;
    end

    assign o_status.complete = complete;
    assign o_status.code     = code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_code <= '0;
        end else if (i_ctrl.restart) begin
            r_idx  <= '0;
            r_code <= '0;
        end else if (i_ctrl.push) begin
            if (complete) begin
                r_idx  <= '0;
                r_code <= '0;
            end else begin
                r_idx  <= idx_eff + 3'd1;
                r_code <= code;
            end
        end
    end

    // history needs no reset, only entries of this subsequence are compared
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && !i_ctrl.restart && !complete) begin
            r_hist[idx_eff] <= i_value;
        end
    end

endmodule

`default_nettype wire

// ===== src/pattern_code_coverage_set.sv =====
// channel  | direction | handshake                 | payload
// input    | in        | i_in_valid / o_in_ready   | i_in (func, value)
// result   | out       | o_out_valid / i_out_ready | o_out (code, new, count, all)
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (pattern_length)
//
// a push that leaves the subsequence open is taken with no found-map access
// a completing push reads its found-map word, then sets its bit and writes it back
// once the result register can take the result; a word whose bit was set is not written
// a clear sweeps the 630-word found map, one word a cycle, with no input taken
// after reset the same sweep runs before the first request is taken
`timescale 1ns / 1ps
`default_nettype none
`include "pattern_code_coverage_set_defines.svh"

module pattern_code_coverage_set import pccs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_req    i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_res        o_out,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [3:0] i_cfg_data
);

    localparam logic [MAP_ADDR_W-1:0] MAP_LAST = MAP_ADDR_W'(MAP_WORDS - 1);

    logic [3:0]            r_cfg_len;
    logic                  r_clearing;
    logic [MAP_ADDR_W-1:0] r_clr_addr;
    logic [15:0]           r_found_total;
    logic                  r_rmw;
    logic [15:0]           r_rmw_code;
    logic [63:0]           r_rd_data;
    logic                  r_out_valid;
    t_out_res              r_out;

    logic [63:0] r_map_mem [MAP_WORDS];

    logic [3:0]            k_eff;
    t_rank_status          rank_st;
    t_rank_ctrl            rank_ctrl;
    logic                  is_clear;
    logic                  in_accept;
    logic                  push_acc;
    logic                  clear_acc;
    logic                  cfg_acc;
    logic                  rd_en;
    logic [MAP_ADDR_W-1:0] rd_addr;
    logic                  rmw_done;
    logic                  was_set;
    logic [15:0]           n_found_total;
    logic                  wr_en;
    logic [MAP_ADDR_W-1:0] wr_addr;
    logic [63:0]           wr_data;

    assign k_eff     = pccs_eff_len(r_cfg_len);
    assign is_clear  = i_in.func == FUNC_CLEAR;
    // a clear or a completing push waits for the pending map update
    assign o_in_ready = !r_clearing && !(r_rmw && (is_clear || rank_st.complete));
    assign in_accept = i_in_valid && o_in_ready;
    assign push_acc  = in_accept && !is_clear;
    assign clear_acc = in_accept && is_clear;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc   = i_cfg_valid && o_cfg_ready;

    assign rank_ctrl.push    = push_acc;
    assign rank_ctrl.restart = clear_acc || cfg_acc;

    pccs_rank_unit u_rank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (rank_ctrl),
        .i_value  (i_in.value),
        .i_len    (k_eff),
        .o_status (rank_st)
    );

    assign rd_en   = push_acc && rank_st.complete;
    assign rd_addr = rank_st.code[MAP_ADDR_W+5:6];

    assign rmw_done      = r_rmw && (!r_out_valid || i_out_ready);
    assign was_set       = r_rd_data[r_rmw_code[5:0]];
    assign n_found_total = r_found_total + 16'(!was_set);

    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = rmw_done && !was_set;
            wr_addr = r_rmw_code[MAP_ADDR_W+5:6];
            wr_data = r_rd_data | (64'd1 << r_rmw_code[5:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map_mem[wr_addr] <= wr_data;
        end
        // read data holds while the update is pending
        if (rd_en) begin
            r_rd_data <= r_map_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len     <= LEN_RESET;
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_found_total <= '0;
            r_rmw         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_acc) begin
                r_cfg_len <= i_cfg_data;
            end
            if (clear_acc) begin
                r_clearing    <= 1'b1;
                r_clr_addr    <= '0;
                r_found_total <= '0;
            end else if (r_clearing) begin
                if (r_clr_addr == MAP_LAST) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + MAP_ADDR_W'(1);
                end
            end else if (rmw_done) begin
                r_found_total <= n_found_total;
            end
            if (rd_en) begin
                r_rmw <= 1'b1;
            end else if (rmw_done) begin
                r_rmw <= 1'b0;
            end
            if (rmw_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rmw_code <= rank_st.code;
        end
        if (rmw_done) begin
            r_out.pattern_code   <= r_rmw_code;
            r_out.newly_found    <= !was_set;
            r_out.distinct_count <= n_found_total;
            r_out.all_found      <= n_found_total == pccs_fact(k_eff);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PCCS_ASSERT_NOW(a_no_read_while_rmw, i_clk, i_rst_n, r_rmw, !rd_en)
    `PCCS_ASSERT_NOW(a_clear_blocks_input, i_clk, i_rst_n, r_clearing, !o_in_ready)
    `PCCS_ASSERT_NEXT(a_new_code_counts, i_clk, i_rst_n, rmw_done && !was_set, r_found_total == $past(r_found_total) + 16'd1)

endmodule

`default_nettype wire
